// ===== hw/rtl/linear_probe_key_set_defines.svh =====
// Assertion macros for the linear probe key set
`ifndef LINEAR_PROBE_KEY_SET_DEFINES_SVH
`define LINEAR_PROBE_KEY_SET_DEFINES_SVH
`ifndef SYNTHESIS
`define LPKS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LPKS_ASSERT(label, clk, rst_n, prop, msg)
`define LPKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lpks_pkg.sv =====
// Shared types and constants of the linear probe key set
`default_nettype none
package lpks_pkg;
	localparam int unsigned TABLE_SLOTS_DEF = 512;
	localparam int unsigned MAX_KEYS_DEF = 341;
	localparam int unsigned KEY_W = 31;

	typedef enum logic {
		FUNC_QUERY = 1'b0,
		FUNC_ADD   = 1'b1
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic is_member;
		logic was_added;
		logic at_limit;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic read;
		logic advance;
		logic write;
		logic clear_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic key_zero;
		logic add;
		logic hit;
		logic empty;
		logic room;
		logic last_probe;
		logic clear_last;
	} dp_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lpks_ram.sv =====
// Single-port RAM with registered read
`default_nettype none
module lpks_ram #(
	parameter int unsigned WIDTH = lpks_pkg::KEY_W,
	parameter int unsigned DEPTH = lpks_pkg::TABLE_SLOTS_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hw/rtl/lpks_datapath.sv =====
// Datapath: key and slot registers, start-slot reduction, slot table, result register
`default_nettype none
module lpks_datapath #(
	parameter int unsigned TABLE_SLOTS = lpks_pkg::TABLE_SLOTS_DEF,
	parameter int unsigned MAX_KEYS = lpks_pkg::MAX_KEYS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpks_pkg::req_t      req,
	input  wire lpks_pkg::dp_cmd_t   cmd,
	output lpks_pkg::dp_status_t     st,
	output lpks_pkg::rsp_t           rsp
);
	localparam int unsigned KW = lpks_pkg::KEY_W;
	localparam int unsigned SW = $clog2(TABLE_SLOTS);
	localparam int unsigned CW = $clog2(MAX_KEYS + 1);
	localparam bit POW2 = (TABLE_SLOTS == (32'd1 << SW));
	localparam int unsigned DIG_W = 4;
	localparam int unsigned DIGITS = (KW + DIG_W - 1) / DIG_W;
	localparam int unsigned SH_W = DIGITS * DIG_W;
	localparam int unsigned DC_W = $clog2(DIGITS + 1);
	localparam int unsigned T_W = SW + DIG_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEYS);

	lpks_pkg::func_t    func_q;
	logic [KW-1:0]      key_q;
	logic [SH_W-1:0]    shift_q;
	logic [DC_W-1:0]    dig_n_q;
	logic [SW-1:0]      idx_q;
	logic [SW-1:0]      probe_n_q;
	logic [CW-1:0]      count_q;
	lpks_pkg::rsp_t     rsp_q;

	logic [T_W-1:0]     part;
	logic [T_W-1:0]     red;
	logic [SW-1:0]      rem_next;
	logic [SW-1:0]      idx_inc;
	logic [KW-1:0]      rdata;
	logic [CW-1:0]      cnt_after;
	lpks_pkg::rsp_t     rsp_next;

	// reduce one digit of the key modulo the slot count
	always_comb begin
		part = {idx_q, shift_q[SH_W-1 -: DIG_W]};
		red = part;
		for (int j = 1; j < (1 << DIG_W); j++) begin
			if (part >= T_W'(j * TABLE_SLOTS)) begin
				red = part - T_W'(j * TABLE_SLOTS);
			end
		end
		rem_next = red[SW-1:0];
	end

	assign idx_inc = (idx_q == LAST_SLOT) ? '0 : idx_q + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			probe_n_q <= '0;
			dig_n_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= POW2 ? req.key[SW-1:0] : '0;
				probe_n_q <= '0;
				dig_n_q <= '0;
			end else if (cmd.mod_step) begin
				idx_q <= rem_next;
				dig_n_q <= dig_n_q + DC_W'(1);
			end else if (cmd.advance || cmd.clear_step) begin
				idx_q <= idx_inc;
				probe_n_q <= probe_n_q + SW'(1);
			end
			if (cmd.write) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			key_q <= req.key;
			shift_q <= SH_W'(req.key);
		end else if (cmd.mod_step) begin
			shift_q <= shift_q << DIG_W;
		end
		if (cmd.out_load) begin
			rsp_q <= rsp_next;
		end
	end

	lpks_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_SLOTS)
	) u_table (
		.clk  (clk),
		.en   (cmd.read || cmd.write || cmd.clear_step),
		.we   (cmd.write || cmd.clear_step),
		.addr (idx_q),
		.wdata(cmd.clear_step ? '0 : key_q),
		.rdata(rdata)
	);

	always_comb begin
		cnt_after = count_q + CW'(cmd.write);
		rsp_next.was_added = cmd.write;
		rsp_next.at_limit = (cnt_after >= MAX_CNT);
		rsp_next.is_member = (key_q != '0) &&
			((rdata == key_q) || cmd.write || (cnt_after >= MAX_CNT));
	end

	always_comb begin
		st.mod_done = POW2 || (dig_n_q == DC_W'(DIGITS));
		st.key_zero = (key_q == '0);
		st.add = (func_q == lpks_pkg::FUNC_ADD);
		st.hit = (rdata == key_q);
		st.empty = (rdata == '0);
		st.room = (count_q < MAX_CNT);
		st.last_probe = (probe_n_q == LAST_SLOT);
		st.clear_last = (idx_q == LAST_SLOT);
	end

	assign rsp = rsp_q;
endmodule
`default_nettype wire

// ===== hw/rtl/lpks_ctrl.sv =====
// Controller: table clearing, start-slot reduction and probe sequencing
`default_nettype none
`include "linear_probe_key_set_defines.svh"
module lpks_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire lpks_pkg::dp_status_t st,
	output lpks_pkg::dp_cmd_t         cmd
);
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CMP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   done;
	logic   add_ok;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign done = st.key_zero || st.hit || st.empty || st.last_probe;
	assign add_ok = !st.key_zero && !st.hit && st.empty && st.add && st.room;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_READ: begin
				cmd.read = st.mod_done;
				cmd.mod_step = !st.mod_done;
			end
			S_CMP: begin
				if (done) begin
					cmd.out_load = out_free;
					cmd.write = out_free && add_ok;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (st.clear_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) state_q <= S_READ;
				end
				S_READ: begin
					if (st.mod_done) state_q <= S_CMP;
				end
				S_CMP: begin
					if (!done) begin
						state_q <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	`LPKS_ASSERT(a_write_empty, clk, arst_n, cmd.write |-> (st.empty && !st.hit && !st.key_zero && st.room), "key written to an occupied slot or beyond the limit")
	`LPKS_ASSERT(a_probe_bound, clk, arst_n, cmd.advance |-> !st.last_probe, "probe ran past the slot count")
	`LPKS_ASSERT(a_clear_quiet, clk, arst_n, (state_q == S_CLEAR) |-> (!rsp_valid_q && !cmd.write), "result or write during the clearing pass")
	`LPKS_ASSERT_NEXT(a_write_result, clk, arst_n, cmd.write, (state_q == S_IDLE) && rsp_valid_q, "add finished without a result")
endmodule
`default_nettype wire

// ===== hw/rtl/linear_probe_key_set.sv =====
// Top level of the linear probe key set
// Result: registered; each probed slot is read from the slot table (S_READ) and compared (S_CMP) in turn,
// after a start-slot reduction over the key's four-bit digits for non-power-of-two slot counts.
// Throughput: one item at a time; req_stall stays high from the input transfer until the result is loaded,
// and a finished probe waits in S_CMP while an earlier result is stalled.
// Reset: asynchronous; a clearing pass over every table slot follows, with req_stall high.
`default_nettype none
module linear_probe_key_set #(
	parameter int unsigned TABLE_SLOTS = lpks_pkg::TABLE_SLOTS_DEF,
	parameter int unsigned MAX_KEYS = lpks_pkg::MAX_KEYS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lpks_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lpks_pkg::rsp_t      rsp
);
	lpks_pkg::dp_cmd_t    cmd;
	lpks_pkg::dp_status_t st;

	lpks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.st       (st),
		.cmd      (cmd)
	);

	lpks_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.MAX_KEYS   (MAX_KEYS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.st    (st),
		.rsp   (rsp)
	);
endmodule
`default_nettype wire
